// ----- rtl/lisc_pkg.sv -----
`default_nettype none

package lisc_pkg;

    localparam int MAX_ITEMS_DEF   = 256;
    localparam int VALUE_WIDTH_DEF = 32;
    localparam int IN_WIDTH        = 32;
    localparam int COUNT_WIDTH     = 32;
    localparam int LEN_OUT_WIDTH   = 9;
    localparam int OUT_DATA_WIDTH  = 48;

    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

    // status of one compare-and-accumulate step
    typedef struct packed {
        logic take;  // candidate length wins, restart count
        logic add;   // candidate length ties, add counts
        logic sat;   // the add saturated or hit the maximum
    } acc_status_t;

endpackage

`default_nettype wire

// ----- rtl/lisc_mem.sv -----
`default_nettype none

module lisc_mem #(
    parameter int DEPTH = lisc_pkg::MAX_ITEMS_DEF,
    parameter int WIDTH = 64
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] store_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            store_reg[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= store_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ----- rtl/lisc_acc.sv -----
`default_nettype none

module lisc_acc #(
    parameter int LEN_WIDTH = 9
) (
    input  wire logic                               en,
    input  wire logic [LEN_WIDTH-1:0]               cur_len,
    input  wire logic [lisc_pkg::COUNT_WIDTH-1:0]   cur_cnt,
    input  wire logic [LEN_WIDTH-1:0]               cand_len,
    input  wire logic [lisc_pkg::COUNT_WIDTH-1:0]   cand_cnt,
    output logic      [LEN_WIDTH-1:0]               out_len,
    output logic      [lisc_pkg::COUNT_WIDTH-1:0]   out_cnt,
    output lisc_pkg::acc_status_t                   status
);

    logic [lisc_pkg::COUNT_WIDTH:0]   sum;
    logic [lisc_pkg::COUNT_WIDTH-1:0] sum_sat;

    always_comb begin
        sum     = {1'b0, cur_cnt} + {1'b0, cand_cnt};
        sum_sat = sum[lisc_pkg::COUNT_WIDTH] ? lisc_pkg::COUNT_MAX
                                             : sum[lisc_pkg::COUNT_WIDTH-1:0];
        status.take = en && (cand_len > cur_len);
        status.add  = en && (cand_len == cur_len);
        status.sat  = status.add && (sum_sat == lisc_pkg::COUNT_MAX);
        priority if (status.take) begin
            out_len = cand_len;
            out_cnt = cand_cnt;
        end else if (status.add) begin
            out_len = cur_len;
            out_cnt = sum_sat;
        end else begin
            out_len = cur_len;
            out_cnt = cur_cnt;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/longest_increasing_subsequence_counter.sv -----
`default_nettype none

// Counts the longest strictly increasing subsequences of a stream of values.
// Input channel s_*: one value per transfer; s_tuser marks a real element,
// s_tlast ends the sequence. A transfer that is not present and not last
// changes nothing. Result channel m_*: one transfer per sequence, issued
// after the item with s_tlast, carrying count, length and two flags.
// Each element is compared against every stored element through one shared
// compare-and-saturating-add unit fed from a table with one write and one
// read port, read one entry per cycle; s_tready stays low while an item is
// being processed. The result is written to the output register from the
// EMIT state, which a scanned last item reaches through UPDATE after its
// scan; if the receiver stalls, the block holds the last item until the
// output register is free, then clears its state for the next sequence.
// Elements beyond MAX_ITEMS are dropped and flagged.
// Reset (aresetn low, synchronous) empties the store and drops any pending
// result; no clearing pass is needed since only written entries are read.
module longest_increasing_subsequence_counter #(
    parameter int MAX_ITEMS   = lisc_pkg::MAX_ITEMS_DEF,
    parameter int VALUE_WIDTH = lisc_pkg::VALUE_WIDTH_DEF
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                s_tvalid,
    output logic                                     s_tready,
    input  wire logic [lisc_pkg::IN_WIDTH-1:0]       s_tdata,   // value
    input  wire logic                                s_tuser,   // present
    input  wire logic                                s_tlast,   // last
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    // lis_count[31:0], lis_length[40:32], count_saturated[41], too_many[42]
    output logic      [lisc_pkg::OUT_DATA_WIDTH-1:0] m_tdata
);

    localparam int LW = $clog2(MAX_ITEMS + 1);
    localparam int AW = $clog2(MAX_ITEMS);
    localparam int CW = lisc_pkg::COUNT_WIDTH;
    localparam int EW = VALUE_WIDTH + LW + CW;

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SCAN   = 2'd1;
    localparam logic [1:0] ST_UPDATE = 2'd2;
    localparam logic [1:0] ST_EMIT   = 2'd3;

    logic [1:0] state_reg, state_next;
    logic [LW-1:0] stored_reg, stored_next;
    logic [LW-1:0] idx_reg, idx_next;
    logic [LW-1:0] best_len_reg, best_len_next;
    logic [CW-1:0] best_cnt_reg, best_cnt_next;
    logic [LW-1:0] mx_reg, mx_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          sat_reg, sat_next;
    logic          ovf_reg, ovf_next;
    logic          rd_vld_reg, rd_vld_next;
    logic          last_reg, last_next;
    logic signed [VALUE_WIDTH-1:0] key_reg, key_next;
    logic          m_valid_reg, m_valid_next;
    logic [lisc_pkg::OUT_DATA_WIDTH-1:0] m_data_reg, m_data_next;

    logic          mem_we, mem_re;
    logic [EW-1:0] mem_wdata, mem_rdata;
    logic signed [VALUE_WIDTH-1:0] rd_val;
    logic [LW-1:0] rd_len;
    logic [CW-1:0] rd_cnt;

    logic          acc_en;
    logic [LW-1:0] acc_cur_len, acc_cand_len, acc_len;
    logic [CW-1:0] acc_cur_cnt, acc_cand_cnt, acc_cnt;
    lisc_pkg::acc_status_t acc_st;

    logic          s_fire, out_free;
    logic [LW-1:0] new_len;

    assign s_tready = (state_reg == ST_IDLE);
    assign s_fire   = s_tvalid && s_tready;
    assign out_free = !m_valid_reg || m_tready;
    assign new_len  = mx_reg + LW'(1);

    assign {rd_val, rd_len, rd_cnt} = mem_rdata;
    assign mem_wdata = {key_reg, new_len, cnt_reg};
    assign mem_we    = (state_reg == ST_UPDATE);
    assign mem_re    = (state_reg == ST_SCAN) && (idx_reg < stored_reg);

    lisc_mem #(
        .DEPTH (MAX_ITEMS),
        .WIDTH (EW)
    ) u_mem (
        .aclk    (aclk),
        .wr_en   (mem_we),
        .wr_addr (stored_reg[AW-1:0]),
        .wr_data (mem_wdata),
        .rd_en   (mem_re),
        .rd_addr (idx_reg[AW-1:0]),
        .rd_data (mem_rdata)
    );

    // shared unit: scans elements in SCAN, merges into the running best in UPDATE
    always_comb begin
        if (state_reg == ST_UPDATE) begin
            acc_en       = 1'b1;
            acc_cur_len  = best_len_reg;
            acc_cur_cnt  = best_cnt_reg;
            acc_cand_len = new_len;
            acc_cand_cnt = cnt_reg;
        end else begin
            acc_en       = (state_reg == ST_SCAN) && rd_vld_reg && (rd_val < key_reg);
            acc_cur_len  = mx_reg;
            acc_cur_cnt  = cnt_reg;
            acc_cand_len = rd_len;
            acc_cand_cnt = rd_cnt;
        end
    end

    lisc_acc #(
        .LEN_WIDTH (LW)
    ) u_acc (
        .en       (acc_en),
        .cur_len  (acc_cur_len),
        .cur_cnt  (acc_cur_cnt),
        .cand_len (acc_cand_len),
        .cand_cnt (acc_cand_cnt),
        .out_len  (acc_len),
        .out_cnt  (acc_cnt),
        .status   (acc_st)
    );

    always_comb begin
        state_next    = state_reg;
        stored_next   = stored_reg;
        idx_next      = idx_reg;
        best_len_next = best_len_reg;
        best_cnt_next = best_cnt_reg;
        mx_next       = mx_reg;
        cnt_next      = cnt_reg;
        sat_next      = sat_reg;
        ovf_next      = ovf_reg;
        rd_vld_next   = mem_re;
        last_next     = last_reg;
        key_next      = key_reg;
        m_valid_next  = m_valid_reg && !m_tready;
        m_data_next   = m_data_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_fire) begin
                    last_next = s_tlast;
                    key_next  = VALUE_WIDTH'($signed(s_tdata));
                    idx_next  = '0;
                    mx_next   = '0;
                    cnt_next  = CW'(1);
                    if (s_tuser && (stored_reg < LW'(MAX_ITEMS))) begin
                        state_next = ST_SCAN;
                    end else begin
                        ovf_next   = ovf_reg || s_tuser;
                        state_next = s_tlast ? ST_EMIT : ST_IDLE;
                    end
                end
            end
            ST_SCAN: begin
                if (mem_re) begin
                    idx_next = idx_reg + LW'(1);
                end
                mx_next  = acc_len;
                cnt_next = acc_cnt;
                sat_next = sat_reg || acc_st.sat;
                if ((idx_reg == stored_reg) && !rd_vld_reg) begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE: begin
                stored_next   = stored_reg + LW'(1);
                best_len_next = acc_len;
                best_cnt_next = acc_cnt;
                sat_next      = sat_reg || acc_st.sat;
                state_next    = last_reg ? ST_EMIT : ST_IDLE;
            end
            ST_EMIT: begin
                if (out_free) begin
                    m_valid_next  = 1'b1;
                    m_data_next   = {5'b0, ovf_reg, sat_reg,
                                     lisc_pkg::LEN_OUT_WIDTH'(best_len_reg), best_cnt_reg};
                    stored_next   = '0;
                    best_len_next = '0;
                    best_cnt_next = '0;
                    sat_next      = 1'b0;
                    ovf_next      = 1'b0;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            stored_reg   <= '0;
            best_len_reg <= '0;
            best_cnt_reg <= '0;
            sat_reg      <= 1'b0;
            ovf_reg      <= 1'b0;
            rd_vld_reg   <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            stored_reg   <= stored_next;
            best_len_reg <= best_len_next;
            best_cnt_reg <= best_cnt_next;
            sat_reg      <= sat_next;
            ovf_reg      <= ovf_next;
            rd_vld_reg   <= rd_vld_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        idx_reg    <= idx_next;
        mx_reg     <= mx_next;
        cnt_reg    <= cnt_next;
        last_reg   <= last_next;
        key_reg    <= key_next;
        m_data_reg <= m_data_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

`ifndef SYNTHESIS
    a_best_within_stored: assert property (@(posedge aclk) disable iff (!aresetn)
        best_len_reg <= stored_reg)
        else $error("best length exceeds stored element count");

    a_write_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        mem_we |-> (stored_reg < LW'(MAX_ITEMS)))
        else $error("table write beyond capacity");

    a_empty_zero_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tdata[40:32] == 9'd0)) |-> (m_tdata[31:0] == 32'd0))
        else $error("nonzero count with zero length");

    a_clear_after_emit: assert property (@(posedge aclk) disable iff (!aresetn)
        ((state_reg == ST_EMIT) && out_free) |=> (stored_reg == '0) && m_tvalid)
        else $error("state not cleared after result");
`endif

endmodule

`default_nettype wire
